// ===== hdl/dcm_pkg.sv =====
// Shared types, constants and arithmetic helpers for the DCM renormalization pipeline.
// No dependencies; every other file in hdl/ refers to this package by scoped names.
`timescale 1ns / 1ps

package dcm_pkg;

    // Number format: signed Q3.20 in 24 bits.
    localparam int W  = 24;
    localparam int F  = 20;
    // Width of the rounded product path (two W+1 bit operands).
    localparam int PW = 2 * W + 2;
    // Width of a squared norm (sum of three rounded squares, never negative).
    localparam int NW = 29;
    // Norm bits that reach the divider (the 1/sqrt band stays below 100.0).
    localparam int DNW = 27;
    // Quotient bits of 2^(3F) / n for n above 0.01, and the remainder that is
    // left over after the leading zero quotient bits.
    localparam int QW = 47;
    localparam int DIV_START = 1 << (3 * F - QW);
    // Root bits of the integer square root.
    localparam int SQ = W;
    // Latency of the factor unit: entry, divider, root load, root steps, select.
    localparam int RSQ_LAT = QW + SQ + 3;
    // Total latency from request to result strobe.
    localparam int TOT_LAT = RSQ_LAT + 10;

    typedef logic signed [W-1:0] t_word;
    typedef t_word [2:0] t_vec;

    typedef struct packed {
        t_word row0_x;
        t_word row0_y;
        t_word row0_z;
        t_word row1_x;
        t_word row1_y;
        t_word row1_z;
    } t_request;

    typedef struct packed {
        t_word out00;
        t_word out01;
        t_word out02;
        t_word out10;
        t_word out11;
        t_word out12;
        t_word out20;
        t_word out21;
        t_word out22;
        t_word ortho_error;
    } t_result;

    // Three matrix rows and the orthogonality error travel together.
    typedef struct packed {
        t_vec  v0;
        t_vec  v1;
        t_vec  v2;
        t_word err;
    } t_rows;

    localparam logic signed [PW-1:0] VMAX = (PW'(1) <<< (W - 1)) - PW'(1);
    localparam logic signed [PW-1:0] VMIN = -VMAX - PW'(1);

    // Fixed-point product, rounded to nearest with ties upward.
    function automatic logic signed [PW-1:0] mulq(input logic signed [W:0] a,
                                                  input logic signed [W:0] b);
        logic signed [PW-1:0] p;
        logic signed [PW-1:0] half;
        p    = a * b;
        half = PW'(1) <<< (F - 1);
        return (p + half) >>> F;
    endfunction

    // Clamp a wide value into the data range.
    function automatic t_word sat_w(input logic signed [PW-1:0] x);
        logic signed [PW-1:0] c;
        if (x > VMAX) begin
            c = VMAX;
        end else if (x < VMIN) begin
            c = VMIN;
        end else begin
            c = x;
        end
        return c[W-1:0];
    endfunction

endpackage

// ===== hdl/dcm_rsqrt.sv =====
// Pipelined renormalization factor unit: band tests, restoring divider and integer root.
// Depends on dcm_pkg for widths and latency constants.
`timescale 1ns / 1ps

module dcm_rsqrt (
    input  logic                   i_clk,
    input  logic [dcm_pkg::NW-1:0] i_norm,
    output logic [dcm_pkg::W-1:0]  o_factor
);

    localparam int XW = 40;
    localparam logic [XW-1:0] ONE = XW'(1) << dcm_pkg::F;

    typedef struct packed {
        logic                  fast;
        logic                  slow;
        logic [dcm_pkg::W-1:0] ff;
    } t_band;

    // Divider stages: remainder, quotient so far, divisor and band info.
    logic [dcm_pkg::DNW-1:0] r_dn   [0:dcm_pkg::QW];
    logic [dcm_pkg::DNW-1:0] r_drem [0:dcm_pkg::QW];
    logic [dcm_pkg::QW-1:0]  r_dq   [0:dcm_pkg::QW];
    t_band                   r_db   [0:dcm_pkg::QW];

    // Root stages: operand bits still to use, partial remainder and root.
    logic [2*dcm_pkg::SQ-1:0] r_sv    [0:dcm_pkg::SQ];
    logic [dcm_pkg::SQ+1:0]   r_srem  [0:dcm_pkg::SQ];
    logic [dcm_pkg::SQ-1:0]   r_sroot [0:dcm_pkg::SQ];
    t_band                    r_sb    [0:dcm_pkg::SQ];

    logic [dcm_pkg::W-1:0] r_fac;

    t_band                   n_band;
    logic [XW-1:0]           n_nx;
    logic signed [XW-1:0]    n_fast;
    logic [dcm_pkg::DNW:0]   n_rx   [0:dcm_pkg::QW-1];
    logic                    n_dge  [0:dcm_pkg::QW-1];
    logic [dcm_pkg::DNW-1:0] n_drem [0:dcm_pkg::QW-1];
    logic [dcm_pkg::SQ+3:0]  n_sx   [0:dcm_pkg::SQ-1];
    logic [dcm_pkg::SQ+3:0]  n_st   [0:dcm_pkg::SQ-1];
    logic                    n_sge  [0:dcm_pkg::SQ-1];
    logic [dcm_pkg::SQ+1:0]  n_srem [0:dcm_pkg::SQ-1];

    // Band tests and the fast factor (3 - n) / 2 on the incoming norm.
    always_comb begin
        n_nx        = XW'(i_norm);
        n_band.fast = (n_nx * XW'(16) < ONE * XW'(25)) && (n_nx * XW'(25) > ONE * XW'(16));
        n_band.slow = (n_nx < ONE * XW'(100)) && (n_nx * XW'(100) > ONE);
        n_fast      = signed'(ONE * XW'(3) - n_nx + XW'(1));
        n_band.ff   = n_fast[dcm_pkg::W:1];
    end

    // One quotient bit of 2^(3F) / n per stage.
    always_comb begin
        for (int k = 0; k < dcm_pkg::QW; k++) begin
            n_rx[k]   = {r_drem[k], 1'b0};
            n_dge[k]  = n_rx[k] >= {1'b0, r_dn[k]};
            n_drem[k] = n_dge[k] ? dcm_pkg::DNW'(n_rx[k] - {1'b0, r_dn[k]})
                                 : dcm_pkg::DNW'(n_rx[k]);
        end
    end

    // One root bit per stage, two operand bits at a time.
    always_comb begin
        for (int j = 0; j < dcm_pkg::SQ; j++) begin
            n_sx[j]   = {r_srem[j], r_sv[j][2*dcm_pkg::SQ-1 -: 2]};
            n_st[j]   = (dcm_pkg::SQ + 4)'({r_sroot[j], 2'b01});
            n_sge[j]  = n_sx[j] >= n_st[j];
            n_srem[j] = n_sge[j] ? (dcm_pkg::SQ + 2)'(n_sx[j] - n_st[j])
                                 : (dcm_pkg::SQ + 2)'(n_sx[j]);
        end
    end

    // Pipeline registers; the unit runs every cycle and holds no control state.
    always_ff @(posedge i_clk) begin
        r_dn[0]   <= i_norm[dcm_pkg::DNW-1:0];
        r_drem[0] <= dcm_pkg::DNW'(dcm_pkg::DIV_START);
        r_dq[0]   <= '0;
        r_db[0]   <= n_band;
        for (int k = 0; k < dcm_pkg::QW; k++) begin
            r_dn[k+1]   <= r_dn[k];
            r_drem[k+1] <= n_drem[k];
            r_dq[k+1]   <= {r_dq[k][dcm_pkg::QW-2:0], n_dge[k]};
            r_db[k+1]   <= r_db[k];
        end
        r_sv[0]    <= (2 * dcm_pkg::SQ)'(r_dq[dcm_pkg::QW]);
        r_srem[0]  <= '0;
        r_sroot[0] <= '0;
        r_sb[0]    <= r_db[dcm_pkg::QW];
        for (int j = 0; j < dcm_pkg::SQ; j++) begin
            r_sv[j+1]    <= r_sv[j] << 2;
            r_srem[j+1]  <= n_srem[j];
            r_sroot[j+1] <= {r_sroot[j][dcm_pkg::SQ-2:0], n_sge[j]};
            r_sb[j+1]    <= r_sb[j];
        end
        priority if (r_sb[dcm_pkg::SQ].fast) begin
            r_fac <= r_sb[dcm_pkg::SQ].ff;
        end else if (r_sb[dcm_pkg::SQ].slow) begin
            r_fac <= dcm_pkg::W'(r_sroot[dcm_pkg::SQ]);
        end else begin
            r_fac <= '0;
        end
    end

    assign o_factor = r_fac;

endmodule

// ===== hdl/dcm_reorthogonalize_unit.sv =====
// Top level of the DCM renormalization pipeline: correction, cross product, scaling.
// Depends on dcm_pkg and instantiates dcm_rsqrt once for each matrix row.
`timescale 1ns / 1ps

// A new request can be issued on every clock cycle; o_busy is always low. Each
// request yields exactly one result strobe on o_valid, in request order. Most of
// the pipeline lies in the factor units: a restoring divider that forms one
// quotient bit per stage, then an integer square root that forms one root bit per
// stage. The result is shown for one cycle only and must be captured then.
module dcm_reorthogonalize_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  dcm_pkg::t_request i_request,
    output logic              o_busy,
    output logic              o_valid,
    output dcm_pkg::t_result  o_result
);

    localparam int L = dcm_pkg::RSQ_LAT;

    logic                      r_vld [0:dcm_pkg::TOT_LAT-1];
    dcm_pkg::t_vec             r1_a, r1_b, r2_a, r2_b, r3_a, r3_b;
    logic signed [dcm_pkg::PW-1:0] r1_p [0:2];
    dcm_pkg::t_word            r2_err, r3_err;
    logic signed [dcm_pkg::PW-1:0] r3_eb [0:2];
    logic signed [dcm_pkg::PW-1:0] r3_ea [0:2];
    dcm_pkg::t_rows            r4_rows, r5_rows, r6_rows, r7_rows, r8_rows;
    logic signed [dcm_pkg::PW-1:0] r5_c [0:5];
    logic signed [dcm_pkg::PW-1:0] r7_sq [0:2][0:2];
    logic [dcm_pkg::NW-1:0]    r8_n [0:2];
    dcm_pkg::t_rows            r_dl [0:L-1];
    logic signed [dcm_pkg::PW-1:0] r9_p [0:2][0:2];
    dcm_pkg::t_word            r9_err;
    logic [2:0]                r9_zero;
    dcm_pkg::t_result          r_res;

    dcm_pkg::t_vec             n_a, n_b;
    logic signed [dcm_pkg::PW-1:0] n_dot;
    logic [dcm_pkg::W-1:0]     n_fac [0:2];
    dcm_pkg::t_vec             n_dv [0:2];

    assign n_a = {i_request.row0_z, i_request.row0_y, i_request.row0_x};
    assign n_b = {i_request.row1_z, i_request.row1_y, i_request.row1_x};
    assign n_dot = r1_p[0] + r1_p[1] + r1_p[2];

    assign n_dv[0] = r_dl[L-1].v0;
    assign n_dv[1] = r_dl[L-1].v1;
    assign n_dv[2] = r_dl[L-1].v2;

    // Request valid travels alongside the data through every stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < dcm_pkg::TOT_LAT; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else begin
            r_vld[0] <= i_start;
            for (int i = 1; i < dcm_pkg::TOT_LAT; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    // Stages one and two: dot product of the input rows and the error term.
    always_ff @(posedge i_clk) begin
        r1_a <= n_a;
        r1_b <= n_b;
        for (int i = 0; i < 3; i++) begin
            r1_p[i] <= dcm_pkg::mulq(signed'(n_a[i]), signed'(n_b[i]));
        end
        r2_a   <= r1_a;
        r2_b   <= r1_b;
        r2_err <= dcm_pkg::sat_w((-n_dot + dcm_pkg::PW'(1)) >>> 1);
    end

    // Stages three and four: each row moves by the error times the other row.
    // The correction terms are kept at full width until the sum is clamped.
    always_ff @(posedge i_clk) begin
        r3_a   <= r2_a;
        r3_b   <= r2_b;
        r3_err <= r2_err;
        for (int i = 0; i < 3; i++) begin
            r3_eb[i] <= dcm_pkg::mulq(r2_err, signed'(r2_b[i]));
            r3_ea[i] <= dcm_pkg::mulq(r2_err, signed'(r2_a[i]));
        end
        r4_rows.err <= r3_err;
        r4_rows.v2  <= '0;
        for (int i = 0; i < 3; i++) begin
            r4_rows.v0[i] <= dcm_pkg::sat_w(dcm_pkg::PW'(signed'(r3_a[i]))
                                            + dcm_pkg::PW'(r3_eb[i]));
            r4_rows.v1[i] <= dcm_pkg::sat_w(dcm_pkg::PW'(signed'(r3_b[i]))
                                            + dcm_pkg::PW'(r3_ea[i]));
        end
    end

    // Stages five and six: third row as the cross product of the corrected rows.
    always_ff @(posedge i_clk) begin
        r5_rows <= r4_rows;
        r5_c[0] <= dcm_pkg::mulq(signed'(r4_rows.v0[1]), signed'(r4_rows.v1[2]));
        r5_c[1] <= dcm_pkg::mulq(signed'(r4_rows.v0[2]), signed'(r4_rows.v1[1]));
        r5_c[2] <= dcm_pkg::mulq(signed'(r4_rows.v0[2]), signed'(r4_rows.v1[0]));
        r5_c[3] <= dcm_pkg::mulq(signed'(r4_rows.v0[0]), signed'(r4_rows.v1[2]));
        r5_c[4] <= dcm_pkg::mulq(signed'(r4_rows.v0[0]), signed'(r4_rows.v1[1]));
        r5_c[5] <= dcm_pkg::mulq(signed'(r4_rows.v0[1]), signed'(r4_rows.v1[0]));
        r6_rows.v0    <= r5_rows.v0;
        r6_rows.v1    <= r5_rows.v1;
        r6_rows.err   <= r5_rows.err;
        r6_rows.v2[0] <= dcm_pkg::sat_w(r5_c[0] - r5_c[1]);
        r6_rows.v2[1] <= dcm_pkg::sat_w(r5_c[2] - r5_c[3]);
        r6_rows.v2[2] <= dcm_pkg::sat_w(r5_c[4] - r5_c[5]);
    end

    // Stages seven and eight: squared norms of all three rows.
    always_ff @(posedge i_clk) begin
        r7_rows <= r6_rows;
        for (int i = 0; i < 3; i++) begin
            r7_sq[0][i] <= dcm_pkg::mulq(signed'(r6_rows.v0[i]), signed'(r6_rows.v0[i]));
            r7_sq[1][i] <= dcm_pkg::mulq(signed'(r6_rows.v1[i]), signed'(r6_rows.v1[i]));
            r7_sq[2][i] <= dcm_pkg::mulq(signed'(r6_rows.v2[i]), signed'(r6_rows.v2[i]));
        end
        r8_rows <= r7_rows;
        for (int k = 0; k < 3; k++) begin
            r8_n[k] <= dcm_pkg::NW'(r7_sq[k][0] + r7_sq[k][1] + r7_sq[k][2]);
        end
    end

    // One factor unit per row.
    for (genvar k = 0; k < 3; k++) begin : g_fac
        dcm_rsqrt u_rsqrt (
            .i_clk    (i_clk),
            .i_norm   (r8_n[k]),
            .o_factor (n_fac[k])
        );
    end

    // Rows wait here while their factors are formed.
    always_ff @(posedge i_clk) begin
        r_dl[0] <= r8_rows;
        for (int i = 1; i < L; i++) begin
            r_dl[i] <= r_dl[i-1];
        end
    end

    // Stages nine and ten: scale each row, clamp and register the result.
    always_ff @(posedge i_clk) begin
        r9_err <= r_dl[L-1].err;
        for (int k = 0; k < 3; k++) begin
            r9_zero[k] <= n_fac[k] == '0;
            for (int i = 0; i < 3; i++) begin
                r9_p[k][i] <= dcm_pkg::mulq(signed'(n_dv[k][i]), signed'({1'b0, n_fac[k]}));
            end
        end
        r_res.out00       <= dcm_pkg::sat_w(r9_p[0][0]);
        r_res.out01       <= dcm_pkg::sat_w(r9_p[0][1]);
        r_res.out02       <= dcm_pkg::sat_w(r9_p[0][2]);
        r_res.out10       <= dcm_pkg::sat_w(r9_p[1][0]);
        r_res.out11       <= dcm_pkg::sat_w(r9_p[1][1]);
        r_res.out12       <= dcm_pkg::sat_w(r9_p[1][2]);
        r_res.out20       <= dcm_pkg::sat_w(r9_p[2][0]);
        r_res.out21       <= dcm_pkg::sat_w(r9_p[2][1]);
        r_res.out22       <= dcm_pkg::sat_w(r9_p[2][2]);
        r_res.ortho_error <= r9_err;
    end

    assign o_busy   = 1'b0;
    assign o_valid  = r_vld[dcm_pkg::TOT_LAT-1];
    assign o_result = r_res;

    // A result strobe always traces back to a request a fixed latency earlier.
    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start, dcm_pkg::TOT_LAT))
        else $error("result strobe without a matching request");

    // A zero factor for the third row must clear that whole row.
    a_row2_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r9_zero[2] |=> (o_result.out20 == '0) && (o_result.out21 == '0)
                       && (o_result.out22 == '0))
        else $error("row two not cleared by a zero factor");

    // No strobe may appear in the cycle right after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_valid)
        else $error("result strobe right after reset");

endmodule

// ===== bench/dcm_reorthogonalize_unit_chk.sv =====
// Checker for the DCM renormalization unit: predicts each result from the request bits.
// Depends on dcm_pkg for the request and result types; instantiated by the bench top.
`timescale 1ns / 1ps

module dcm_reorthogonalize_unit_chk (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  dcm_pkg::t_request i_request,
    input  logic              i_busy,
    input  logic              i_valid,
    input  dcm_pkg::t_result  i_result,
    output int                o_pending,
    output int                o_errors
);

    localparam longint ONE  = longint'(1) << dcm_pkg::F;
    localparam longint WMAX = (longint'(1) << (dcm_pkg::W - 1)) - 1;
    localparam longint WMIN = -WMAX - 1;

    dcm_pkg::t_result renorm_q[$];
    string            field_name[10] = '{"out00", "out01", "out02", "out10", "out11",
                                         "out12", "out20", "out21", "out22", "ortho_error"};

    // Clamp to the data range.
    function automatic longint clamp(input longint x);
        if (x > WMAX) return WMAX;
        if (x < WMIN) return WMIN;
        return x;
    endfunction

    // Product rounded to nearest, ties upward.
    function automatic longint qmul(input longint a, input longint b);
        return (a * b + (longint'(1) << (dcm_pkg::F - 1))) >>> dcm_pkg::F;
    endfunction

    function automatic longint sq_norm(input longint v[3]);
        return qmul(v[0], v[0]) + qmul(v[1], v[1]) + qmul(v[2], v[2]);
    endfunction

    // Scale factor from the squared norm: fast band, inverse root band, or zero.
    function automatic longint scale_factor(input longint n);
        logic [127:0] t;
        logic [127:0] lim;
        longint       s;
        s   = 0;
        lim = 128'd1 << (3 * dcm_pkg::F);
        if (16 * n < 25 * ONE && 25 * n > 16 * ONE) return (3 * ONE - n + 1) / 2;
        if (n < 100 * ONE && 100 * n > ONE) begin
            for (int b = dcm_pkg::F + 3; b >= 0; b--) begin
                t = 128'(s | (longint'(1) << b));
                if (t * t * 128'(n) <= lim) s = longint'(t);
            end
            return s;
        end
        return 0;
    endfunction

    function automatic dcm_pkg::t_result predict_renorm(input dcm_pkg::t_request rq);
        dcm_pkg::t_result r;
        longint a[3], b[3], r0[3], r1[3], r2[3];
        longint dot, err, s0, s1, s2;
        a[0] = longint'(rq.row0_x); a[1] = longint'(rq.row0_y); a[2] = longint'(rq.row0_z);
        b[0] = longint'(rq.row1_x); b[1] = longint'(rq.row1_y); b[2] = longint'(rq.row1_z);
        dot = qmul(a[0], b[0]) + qmul(a[1], b[1]) + qmul(a[2], b[2]);
        err = clamp((1 - dot) >>> 1);
        for (int i = 0; i < 3; i++) begin
            r0[i] = clamp(a[i] + qmul(err, b[i]));
            r1[i] = clamp(b[i] + qmul(err, a[i]));
        end
        r2[0] = clamp(qmul(r0[1], r1[2]) - qmul(r0[2], r1[1]));
        r2[1] = clamp(qmul(r0[2], r1[0]) - qmul(r0[0], r1[2]));
        r2[2] = clamp(qmul(r0[0], r1[1]) - qmul(r0[1], r1[0]));
        s0 = scale_factor(sq_norm(r0));
        s1 = scale_factor(sq_norm(r1));
        s2 = scale_factor(sq_norm(r2));
        r.out00 = 24'(clamp(qmul(r0[0], s0)));
        r.out01 = 24'(clamp(qmul(r0[1], s0)));
        r.out02 = 24'(clamp(qmul(r0[2], s0)));
        r.out10 = 24'(clamp(qmul(r1[0], s1)));
        r.out11 = 24'(clamp(qmul(r1[1], s1)));
        r.out12 = 24'(clamp(qmul(r1[2], s1)));
        r.out20 = 24'(clamp(qmul(r2[0], s2)));
        r.out21 = 24'(clamp(qmul(r2[1], s2)));
        r.out22 = 24'(clamp(qmul(r2[2], s2)));
        r.ortho_error = 24'(err);
        return r;
    endfunction

    // Record accepted requests and compare each strobed result with the oldest one.
    always @(posedge i_clk) begin
        dcm_pkg::t_result want;
        logic [23:0]      ev;
        logic [23:0]      av;
        int               bad;
        bad = 0;
        if (!i_rst_n) begin
            renorm_q.delete();
            o_errors  <= 0;
            o_pending <= 0;
        end else begin
            if (i_valid) begin
                if (renorm_q.size() == 0) begin
                    $error("result strobe with no request outstanding");
                    bad = bad + 1;
                end else begin
                    want = renorm_q.pop_front();
                    for (int i = 0; i < 10; i++) begin
                        ev = want[(9 - i) * 24 +: 24];
                        av = i_result[(9 - i) * 24 +: 24];
                        if (ev !== av) begin
                            $error("%s: expected %0d, got %0d", field_name[i],
                                   $signed(ev), $signed(av));
                            bad = bad + 1;
                        end
                    end
                end
            end
            if (i_start && !i_busy) renorm_q.push_back(predict_renorm(i_request));
            o_errors  <= o_errors + bad;
            o_pending <= renorm_q.size();
        end
    end

endmodule

// ===== bench/dcm_reorthogonalize_unit_tb.sv =====
// Bench top for the DCM renormalization unit: clock, reset, request stimulus, verdict.
// Depends on dcm_pkg, dcm_reorthogonalize_unit and dcm_reorthogonalize_unit_chk.
`timescale 1ns / 1ps

module dcm_reorthogonalize_unit_tb;

    localparam int ONE_Q = 1 << dcm_pkg::F;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_start;
    dcm_pkg::t_request i_request;
    logic              o_busy;
    logic              o_valid;
    dcm_pkg::t_result  o_result;
    int                pending;
    int                errors;
    int                idle_pct;

    dcm_reorthogonalize_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_request(i_request),
        .o_busy   (o_busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    dcm_reorthogonalize_unit_chk chk (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_request(i_request),
        .i_busy   (o_busy),
        .i_valid  (o_valid),
        .i_result (o_result),
        .o_pending(pending),
        .o_errors (errors)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Hard stop in case the unit stops producing results.
    initial begin
        #5ms;
        $display("dcm_reorthogonalize_unit_tb: FAIL");
        $finish;
    end

    // Hold one request until it is accepted, then possibly leave a gap.
    task automatic issue_request(input dcm_pkg::t_request rq);
        logic taken;
        i_start   <= 1'b1;
        i_request <= rq;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = !o_busy;
            @(posedge i_clk);
        end
        if ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    function automatic dcm_pkg::t_request make_rows(input int a0, a1, a2, b0, b1, b2);
        dcm_pkg::t_request rq;
        rq.row0_x = 24'(a0); rq.row0_y = 24'(a1); rq.row0_z = 24'(a2);
        rq.row1_x = 24'(b0); rq.row1_y = 24'(b1); rq.row1_z = 24'(b2);
        return rq;
    endfunction

    // Near-rotation component, or occasionally any code at all.
    function automatic int pick_word();
        int m;
        m = $urandom_range(9);
        if (m < 6) return $signed($urandom_range(0, 2 * ONE_Q)) - ONE_Q;
        if (m < 8) return $signed($urandom_range(0, ONE_Q / 4)) - ONE_Q / 8;
        return $signed(24'($urandom));
    endfunction

    initial begin
        dcm_pkg::t_request rq;
        i_rst_n   <= 1'b0;
        i_start   <= 1'b0;
        i_request <= '0;
        idle_pct  = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: identity, zero rows, extremes, band edges and out-of-band norms.
        issue_request(make_rows(ONE_Q, 0, 0, 0, ONE_Q, 0));
        issue_request(make_rows(0, 0, 0, 0, 0, 0));
        issue_request(make_rows(8388607, 8388607, 8388607, 8388607, 8388607, 8388607));
        issue_request(make_rows(-8388608, -8388608, -8388608, -8388608, -8388608, -8388608));
        issue_request(make_rows(8388607, -8388608, 8388607, -8388608, 8388607, -8388608));
        issue_request(make_rows(-8388608, 0, 0, 8388607, 0, 0));
        issue_request(make_rows(1310720, 0, 0, 0, 0, 0));
        issue_request(make_rows(1310720, 0, 0, 0, 1310720, 0));
        issue_request(make_rows(838861, 0, 0, 0, 838860, 0));
        issue_request(make_rows(838860, 0, 0, 0, 838861, 0));
        issue_request(make_rows(104858, 0, 0, 0, 104857, 0));
        issue_request(make_rows(104857, 0, 0, 0, 104858, 0));
        issue_request(make_rows(7 * ONE_Q, 7 * ONE_Q, 0, 0, 0, 1));
        issue_request(make_rows(6 * ONE_Q, 5 * ONE_Q, 5 * ONE_Q, 0, 0, 0));
        issue_request(make_rows(1, 0, 0, 0, -1, 0));
        issue_request(make_rows(ONE_Q, ONE_Q / 2, 0, ONE_Q, -ONE_Q / 2, 0));
        issue_request(make_rows(741455, 741455, 0, -741455, 741455, 0));
        issue_request(make_rows(0, 0, ONE_Q, ONE_Q, 0, 0));

        // Pause until the pipeline has drained completely.
        i_start <= 1'b0;
        while (pending != 0) @(posedge i_clk);

        // Random requests in three idling phases.
        for (int ph = 0; ph < 3; ph++) begin
            idle_pct = (ph == 0) ? 32 : (ph == 1) ? 55 : 0;
            for (int k = 0; k < 560; k++) begin
                rq = make_rows(pick_word(), pick_word(), pick_word(),
                               pick_word(), pick_word(), pick_word());
                issue_request(rq);
            end
        end
        i_start <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (dcm_pkg::TOT_LAT + 16) @(posedge i_clk);
        if (errors == 0) begin
            $display("dcm_reorthogonalize_unit_tb: PASS");
        end else begin
            $display("dcm_reorthogonalize_unit_tb: FAIL");
        end
        $finish;
    end

endmodule
